// ===== hw/rtl/cds_pkg.sv =====
// ----------------------------------------------------------------------------
// Calendar date subtractor package
// Shared field widths, command and operation codes, controller status, and the
// month length lookup used by the controller and datapath.
// ----------------------------------------------------------------------------
package cds_pkg;

   localparam int COUNT_BITS_DEFAULT = 16;

   localparam int CMD_W       = 3;
   localparam int CNT_FIELD_W = 16;
   localparam int DAY_W       = 5;
   localparam int MONTH_W     = 4;
   localparam int YEAR_W      = 14;
   localparam int CENT_W      = 7;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 24;

   localparam logic [31:0]        DAYS_400Y  = 32'd146097;
   localparam logic [YEAR_W-1:0]  YEAR_ONE   = 14'd1;
   localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
   localparam logic [YEAR_W-1:0]  YEARS_400  = 14'd400;
   localparam logic [YEAR_W-1:0]  CENT_YEARS = 14'd100;
   localparam logic [CENT_W-1:0]  CENTS_400  = 7'd4;
   localparam logic [CENT_W-1:0]  YY_MAX     = 7'd99;
   localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
   localparam logic [DAY_W-1:0]   DAY_ONE    = 5'd1;

   // Division by 100 as a multiply by a scaled reciprocal, exact for years up to 9999.
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int          RECIP_SHIFT = 19;
   localparam int          RECIP_W     = 27;

   localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   typedef enum logic [CMD_W-1:0] {
      CMD_DAYS         = 3'd0,
      CMD_WEEKS        = 3'd1,
      CMD_MONTHS       = 3'd2,
      CMD_YEARS        = 3'd3,
      CMD_YEARS_DIRECT = 3'd4
   } cmd_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SPLIT,
      OP_CLAMP,
      OP_DIRECT,
      OP_DAY,
      OP_MONTH,
      OP_YEAR,
      OP_EMIT
   } op_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             uf;
      logic             cnt_zero;
      logic             back_zero;
   } status_type;

   function automatic logic is_leap(logic [CENT_W-1:0] cent, logic [CENT_W-1:0] yy);
      return (yy != '0) ? (yy[1:0] == 2'b00) : (cent[1:0] == 2'b00);
   endfunction

   function automatic logic [DAY_W-1:0] month_days(logic [MONTH_W-1:0] m, logic leap);
      logic [DAY_W-1:0] len;
      len = MONTH_LEN[m - MONTH_JAN];
      if (m == MONTH_FEB && leap) begin
         len = len + DAY_ONE;
      end
      return len;
   endfunction

endpackage

// ===== hw/rtl/cds_datapath.sv =====
// ----------------------------------------------------------------------------
// Calendar date subtractor datapath
// Holds the working date, counters and result register, and carries out one
// operation per cycle as commanded by the controller.
// ----------------------------------------------------------------------------
module cds_datapath #(
   parameter int COUNT_BITS = cds_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cds_pkg::op_type               op,
   output cds_pkg::status_type           status,
   input  logic [cds_pkg::CMD_W-1:0]     command,
   input  logic [cds_pkg::CNT_FIELD_W-1:0] count,
   input  logic [cds_pkg::DAY_W-1:0]     day_in,
   input  logic [cds_pkg::MONTH_W-1:0]   month_in,
   input  logic [cds_pkg::YEAR_W-1:0]    year_in,
   output logic [cds_pkg::DAY_W-1:0]     day_out,
   output logic [cds_pkg::MONTH_W-1:0]   month_out,
   output logic [cds_pkg::YEAR_W-1:0]    year_out,
   output logic                          underflow
);

   localparam int CNT_W  = (COUNT_BITS < cds_pkg::CNT_FIELD_W) ? COUNT_BITS
                                                              : cds_pkg::CNT_FIELD_W;
   localparam int BACK_W = CNT_W + 3;

   logic [cds_pkg::CMD_W-1:0]   cmd_ff;
   logic [CNT_W-1:0]            cnt_ff;
   logic [BACK_W-1:0]           back_ff;
   logic [cds_pkg::DAY_W-1:0]   d_ff;
   logic [cds_pkg::MONTH_W-1:0] m_ff;
   logic [cds_pkg::YEAR_W-1:0]  y_ff;
   logic [cds_pkg::CENT_W-1:0]  cent_ff;
   logic [cds_pkg::CENT_W-1:0]  yy_ff;
   logic                        uf_ff;

   logic [cds_pkg::DAY_W-1:0]   day_out_ff;
   logic [cds_pkg::MONTH_W-1:0] month_out_ff;
   logic [cds_pkg::YEAR_W-1:0]  year_out_ff;
   logic                        underflow_ff;

   logic [CNT_W-1:0]            cnt_in;
   logic [BACK_W-1:0]           back_in;
   logic [cds_pkg::MONTH_W-1:0] m_clamp;
   logic [cds_pkg::YEAR_W-1:0]  y_clamp;
   logic [cds_pkg::RECIP_W-1:0] y_prod;
   logic [cds_pkg::CENT_W-1:0]  cent_split;
   logic [cds_pkg::CENT_W-1:0]  yy_split;
   logic [cds_pkg::CENT_W-1:0]  cent_dec;
   logic [cds_pkg::CENT_W-1:0]  yy_dec;
   logic                        leap_cur;
   logic                        leap_dec;
   logic                        jan;
   logic [cds_pkg::MONTH_W-1:0] m_prev;
   logic [cds_pkg::YEAR_W-1:0]  y_pm;
   logic [cds_pkg::CENT_W-1:0]  cent_pm;
   logic [cds_pkg::CENT_W-1:0]  yy_pm;
   logic [cds_pkg::DAY_W-1:0]   dim_cur;
   logic [cds_pkg::DAY_W-1:0]   dim_pm;
   logic [cds_pkg::DAY_W-1:0]   dim_py;
   logic                        year_one;
   logic                        first_month;
   logic                        leap_jump;

   always_comb begin
      cnt_in  = count[CNT_W-1:0];
      back_in = BACK_W'(cnt_in);
      if (command == cds_pkg::CMD_WEEKS) begin
         back_in = (BACK_W'(cnt_in) << 3) - BACK_W'(cnt_in);
      end

      m_clamp = month_in;
      if (month_in < cds_pkg::MONTH_JAN) begin
         m_clamp = cds_pkg::MONTH_JAN;
      end else if (month_in > cds_pkg::MONTH_DEC) begin
         m_clamp = cds_pkg::MONTH_DEC;
      end
      y_clamp = year_in;
      if (year_in < cds_pkg::YEAR_ONE) begin
         y_clamp = cds_pkg::YEAR_ONE;
      end else if (year_in > cds_pkg::YEAR_MAX) begin
         y_clamp = cds_pkg::YEAR_MAX;
      end

      y_prod     = cds_pkg::RECIP_W'(y_ff) * cds_pkg::RECIP_W'(cds_pkg::RECIP_100);
      cent_split = y_prod[cds_pkg::RECIP_SHIFT +: cds_pkg::CENT_W];
      yy_split   = cds_pkg::CENT_W'(y_ff - cds_pkg::YEAR_W'(cent_split) * cds_pkg::CENT_YEARS);

      if (yy_ff == '0) begin
         cent_dec = cent_ff - 1'b1;
         yy_dec   = cds_pkg::YY_MAX;
      end else begin
         cent_dec = cent_ff;
         yy_dec   = yy_ff - 1'b1;
      end
      leap_cur = cds_pkg::is_leap(cent_ff, yy_ff);
      leap_dec = cds_pkg::is_leap(cent_dec, yy_dec);

      jan = (m_ff == cds_pkg::MONTH_JAN);
      if (jan) begin
         m_prev  = cds_pkg::MONTH_DEC;
         y_pm    = y_ff - 1'b1;
         cent_pm = cent_dec;
         yy_pm   = yy_dec;
      end else begin
         m_prev  = m_ff - 1'b1;
         y_pm    = y_ff;
         cent_pm = cent_ff;
         yy_pm   = yy_ff;
      end

      dim_cur = cds_pkg::month_days(m_ff, leap_cur);
      dim_pm  = cds_pkg::month_days(m_prev, jan ? leap_dec : leap_cur);
      dim_py  = cds_pkg::month_days(m_ff, leap_dec);

      year_one    = (y_ff == cds_pkg::YEAR_ONE);
      first_month = jan && year_one;
      leap_jump   = (32'(back_ff) >= cds_pkg::DAYS_400Y) && (y_ff > cds_pkg::YEARS_400);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         uf_ff <= 1'b0;
      end else begin
         unique case (op)
            cds_pkg::OP_LOAD: begin
               cmd_ff  <= command;
               cnt_ff  <= cnt_in;
               back_ff <= back_in;
               d_ff    <= day_in;
               m_ff    <= m_clamp;
               y_ff    <= y_clamp;
               uf_ff   <= 1'b0;
            end
            cds_pkg::OP_SPLIT: begin
               cent_ff <= cent_split;
               yy_ff   <= yy_split;
            end
            cds_pkg::OP_CLAMP: begin
               if (d_ff == '0) begin
                  d_ff <= cds_pkg::DAY_ONE;
               end else if (d_ff > dim_cur) begin
                  d_ff <= dim_cur;
               end
            end
            cds_pkg::OP_DIRECT: begin
               if (32'(cnt_ff) >= 32'(y_ff)) begin
                  uf_ff <= 1'b1;
               end else begin
                  y_ff <= cds_pkg::YEAR_W'(32'(y_ff) - 32'(cnt_ff));
               end
            end
            cds_pkg::OP_DAY: begin
               priority if (leap_jump) begin
                  back_ff <= back_ff - BACK_W'(cds_pkg::DAYS_400Y);
                  y_ff    <= y_ff - cds_pkg::YEARS_400;
                  cent_ff <= cent_ff - cds_pkg::CENTS_400;
               end else if (back_ff < BACK_W'(d_ff)) begin
                  d_ff    <= d_ff - back_ff[cds_pkg::DAY_W-1:0];
                  back_ff <= '0;
               end else if (first_month) begin
                  uf_ff <= 1'b1;
               end else begin
                  back_ff <= back_ff - BACK_W'(d_ff);
                  m_ff    <= m_prev;
                  y_ff    <= y_pm;
                  cent_ff <= cent_pm;
                  yy_ff   <= yy_pm;
                  d_ff    <= dim_pm;
               end
            end
            cds_pkg::OP_MONTH: begin
               if (first_month) begin
                  uf_ff <= 1'b1;
               end else begin
                  cnt_ff  <= cnt_ff - 1'b1;
                  m_ff    <= m_prev;
                  y_ff    <= y_pm;
                  cent_ff <= cent_pm;
                  yy_ff   <= yy_pm;
                  if (d_ff > dim_pm) begin
                     d_ff <= dim_pm;
                  end
               end
            end
            cds_pkg::OP_YEAR: begin
               if (year_one) begin
                  uf_ff <= 1'b1;
               end else begin
                  cnt_ff  <= cnt_ff - 1'b1;
                  y_ff    <= y_ff - 1'b1;
                  cent_ff <= cent_dec;
                  yy_ff   <= yy_dec;
                  if (d_ff > dim_py) begin
                     d_ff <= dim_py;
                  end
               end
            end
            cds_pkg::OP_EMIT: begin
               underflow_ff <= uf_ff;
               if (uf_ff) begin
                  day_out_ff   <= cds_pkg::DAY_ONE;
                  month_out_ff <= cds_pkg::MONTH_JAN;
                  year_out_ff  <= cds_pkg::YEAR_ONE;
               end else begin
                  day_out_ff   <= d_ff;
                  month_out_ff <= m_ff;
                  year_out_ff  <= y_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign status.cmd       = cmd_ff;
   assign status.uf        = uf_ff;
   assign status.cnt_zero  = (cnt_ff == '0);
   assign status.back_zero = (back_ff == '0);

   assign day_out   = day_out_ff;
   assign month_out = month_out_ff;
   assign year_out  = year_out_ff;
   assign underflow = underflow_ff;

endmodule

// ===== hw/rtl/cds_ctrl.sv =====
// ----------------------------------------------------------------------------
// Calendar date subtractor controller
// Sequences load, normalization, stepping and result hand-off, and owns the
// request and response handshakes.
// ----------------------------------------------------------------------------
module cds_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  cds_pkg::status_type status,
   output cds_pkg::op_type     op
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SPLIT,
      ST_CLAMP,
      ST_DAY,
      ST_MONTH,
      ST_YEAR,
      ST_DIRECT,
      ST_RESPLIT,
      ST_RECLAMP,
      ST_DONE
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      op = cds_pkg::OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op = cds_pkg::OP_LOAD;
            end
         end
         ST_SPLIT, ST_RESPLIT: op = cds_pkg::OP_SPLIT;
         ST_CLAMP, ST_RECLAMP: op = cds_pkg::OP_CLAMP;
         ST_DIRECT:            op = cds_pkg::OP_DIRECT;
         ST_DAY: begin
            if (!status.back_zero && !status.uf) begin
               op = cds_pkg::OP_DAY;
            end
         end
         ST_MONTH: begin
            if (!status.cnt_zero && !status.uf) begin
               op = cds_pkg::OP_MONTH;
            end
         end
         ST_YEAR: begin
            if (!status.cnt_zero && !status.uf) begin
               op = cds_pkg::OP_YEAR;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               op = cds_pkg::OP_EMIT;
            end
         end
         default: op = cds_pkg::OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_DONE && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= ST_SPLIT;
               end
            end
            ST_SPLIT: state_ff <= ST_CLAMP;
            ST_CLAMP: begin
               unique case (status.cmd)
                  cds_pkg::CMD_DAYS,
                  cds_pkg::CMD_WEEKS:        state_ff <= ST_DAY;
                  cds_pkg::CMD_MONTHS:       state_ff <= ST_MONTH;
                  cds_pkg::CMD_YEARS:        state_ff <= ST_YEAR;
                  cds_pkg::CMD_YEARS_DIRECT: state_ff <= ST_DIRECT;
                  default:                   state_ff <= ST_DONE;
               endcase
            end
            ST_DAY: begin
               if (status.back_zero || status.uf) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_MONTH, ST_YEAR: begin
               if (status.cnt_zero || status.uf) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DIRECT:  state_ff <= ST_RESPLIT;
            ST_RESPLIT: state_ff <= ST_RECLAMP;
            ST_RECLAMP: state_ff <= ST_DONE;
            ST_DONE: begin
               if (slot_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ===== hw/rtl/calendar_date_subtractor.sv =====
// A new request word is accepted only once the previous word has been stepped through
// and its result moved to the response register; a finished result may wait for a free slot.
// Days and weeks step once per 400-year jump, once per month boundary crossed and once
// for a final partial month; months and years stepwise step once per unit of count.
// Synchronous active-high reset returns the controller to idle with no result held.
// ----------------------------------------------------------------------------
// Calendar date subtractor
// Moves a Gregorian date back by a count of days, weeks, months or years.
// ----------------------------------------------------------------------------
module calendar_date_subtractor #(
   parameter int COUNT_BITS = cds_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // command[2:0], count[18:3], day_in[23:19], month_in[27:24], year_in[41:28]
   input  logic [cds_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // day_out[4:0], month_out[8:5], year_out[22:9]
   output logic [cds_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // underflow[0]
   output logic [0:0]                      rsp_tuser
);

   cds_pkg::op_type     op;
   cds_pkg::status_type status;

   logic [cds_pkg::DAY_W-1:0]   day_out;
   logic [cds_pkg::MONTH_W-1:0] month_out;
   logic [cds_pkg::YEAR_W-1:0]  year_out;
   logic                        underflow;

   cds_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .op         (op)
   );

   cds_datapath #(
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .status    (status),
      .command   (req_tdata[2:0]),
      .count     (req_tdata[18:3]),
      .day_in    (req_tdata[23:19]),
      .month_in  (req_tdata[27:24]),
      .year_in   (req_tdata[41:28]),
      .day_out   (day_out),
      .month_out (month_out),
      .year_out  (year_out),
      .underflow (underflow)
   );

   assign rsp_tdata = {1'b0, year_out, month_out, day_out};
   assign rsp_tuser = underflow;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("Request accepted while a word is still in progress.");

   a_result_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[4:0] != 5'd0 && rsp_tdata[8:5] != 4'd0
                     && rsp_tdata[8:5] <= 4'd12 && rsp_tdata[22:9] != 14'd0
                     && rsp_tdata[22:9] <= 14'd9999)
      else $error("Result date out of range.");

   a_underflow_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[4:0] == 5'd1 && rsp_tdata[8:5] == 4'd1
                                     && rsp_tdata[22:9] == 14'd1)
      else $error("Underflow result is not saturated to the first day of year one.");

endmodule

// ===== tb/sv/calendar_date_subtractor_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date subtractor testbench
// Drives dated requests through the request stream with random gaps and
// back-pressure, predicts each resulting date in the bench, and compares
// every response word field by field in arrival order.
// ----------------------------------------------------------------------------
module calendar_date_subtractor_tb;

   localparam int COUNT_BITS   = cds_pkg::COUNT_BITS_DEFAULT;
   localparam int RANDOM_ITEMS = 2000;
   localparam int REQ_USED_W   = cds_pkg::CMD_W + cds_pkg::CNT_FIELD_W + cds_pkg::DAY_W
                                 + cds_pkg::MONTH_W + cds_pkg::YEAR_W;
   localparam int RSP_USED_W   = cds_pkg::DAY_W + cds_pkg::MONTH_W + cds_pkg::YEAR_W;

   localparam logic [cds_pkg::CMD_W-1:0] CMD_UNKNOWN_LO = cds_pkg::CMD_YEARS_DIRECT + 3'd1;
   localparam logic [cds_pkg::CMD_W-1:0] CMD_UNKNOWN_HI = '1;

   typedef struct packed {
      logic [cds_pkg::CMD_W-1:0]       cmd;
      logic [cds_pkg::CNT_FIELD_W-1:0] count;
      logic [cds_pkg::DAY_W-1:0]       day;
      logic [cds_pkg::MONTH_W-1:0]     month;
      logic [cds_pkg::YEAR_W-1:0]      year;
      logic                            drain;
   } date_req_type;

   typedef struct packed {
      logic [cds_pkg::DAY_W-1:0]   day;
      logic [cds_pkg::MONTH_W-1:0] month;
      logic [cds_pkg::YEAR_W-1:0]  year;
      logic                        underflow;
   } date_rsp_type;

   logic                               clock      = 1'b0;
   logic                               reset      = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [cds_pkg::REQ_DATA_W-1:0]     req_tdata  = '0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [cds_pkg::RSP_DATA_W-1:0]     rsp_tdata;
   logic [0:0]                         rsp_tuser;

   date_req_type pending_q[$];
   date_rsp_type date_expect_q[$];
   int           mismatches = 0;
   int           send_wait  = 0;
   int           send_calm  = 0;
   int           recv_wait  = 0;
   int           recv_calm  = 0;

   calendar_date_subtractor #(
      .COUNT_BITS(COUNT_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic bit leap_year(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
      case (m)
         2:          return leap_year(y) ? 29 : 28;
         4, 6, 9, 11: return 30;
         default:    return 31;
      endcase
   endfunction

   function automatic int unsigned day_number(int unsigned d, int unsigned m, int unsigned y);
      int unsigned p;
      int unsigned n;
      p = y - 1;
      n = 365 * p + p / 4 - p / 100 + p / 400;
      for (int unsigned k = 1; k < m; k++) begin
         n += days_in_month(k, y);
      end
      return n + d - 1;
   endfunction

   function automatic date_rsp_type shift_date_back(date_req_type w);
      date_rsp_type res;
      int unsigned  cnt, d, m, y, n, back, rem, q400, q100, q4, q1;
      bit           uf;
      cnt = 32'(w.count) & ((32'd1 << COUNT_BITS) - 1);
      d = 32'(w.day);
      m = 32'(w.month);
      y = 32'(w.year);
      uf = 1'b0;
      if (m < 1) m = 1;
      if (m > 12) m = 12;
      if (y < 1) y = 1;
      if (y > 9999) y = 9999;
      if (d < 1) d = 1;
      if (d > days_in_month(m, y)) d = days_in_month(m, y);

      case (w.cmd)
         cds_pkg::CMD_DAYS, cds_pkg::CMD_WEEKS: begin
            back = (w.cmd == cds_pkg::CMD_WEEKS) ? cnt * 7 : cnt;
            n = day_number(d, m, y);
            if (n < back) begin
               uf = 1'b1;
            end else begin
               rem = n - back;
               q400 = rem / 146097;
               rem = rem % 146097;
               q100 = rem / 36524;
               if (q100 == 4) q100 = 3;
               rem -= q100 * 36524;
               q4 = rem / 1461;
               rem = rem % 1461;
               q1 = rem / 365;
               if (q1 == 4) q1 = 3;
               rem -= q1 * 365;
               y = 400 * q400 + 100 * q100 + 4 * q4 + q1 + 1;
               m = 1;
               while (m < 12 && rem >= days_in_month(m, y)) begin
                  rem -= days_in_month(m, y);
                  m++;
               end
               d = rem + 1;
            end
         end
         cds_pkg::CMD_MONTHS: begin
            for (int unsigned i = 0; i < cnt && !uf; i++) begin
               if (m == 1) begin
                  if (y == 1) begin
                     uf = 1'b1;
                  end else begin
                     m = 12;
                     y--;
                  end
               end else begin
                  m--;
               end
               if (d > days_in_month(m, y)) d = days_in_month(m, y);
            end
         end
         cds_pkg::CMD_YEARS: begin
            for (int unsigned i = 0; i < cnt && !uf; i++) begin
               if (y == 1) begin
                  uf = 1'b1;
               end else begin
                  y--;
                  if (d > days_in_month(m, y)) d = days_in_month(m, y);
               end
            end
         end
         cds_pkg::CMD_YEARS_DIRECT: begin
            if (cnt >= y) begin
               uf = 1'b1;
            end else begin
               y -= cnt;
               if (d > days_in_month(m, y)) d = days_in_month(m, y);
            end
         end
         default: begin
         end
      endcase

      if (uf) begin
         d = 1;
         m = 1;
         y = 1;
      end
      res.day = cds_pkg::DAY_W'(d);
      res.month = cds_pkg::MONTH_W'(m);
      res.year = cds_pkg::YEAR_W'(y);
      res.underflow = uf;
      return res;
   endfunction

   function automatic int draw_wait(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 31) == 0) begin
         calm_left = $urandom_range(20, 60);
         return 0;
      end
      return $urandom_range(0, 8);
   endfunction

   task automatic add_item(logic [cds_pkg::CMD_W-1:0] cmd,
                           logic [cds_pkg::CNT_FIELD_W-1:0] cnt,
                           logic [cds_pkg::DAY_W-1:0] d, logic [cds_pkg::MONTH_W-1:0] m,
                           logic [cds_pkg::YEAR_W-1:0] y, bit drain);
      date_req_type w;
      w.cmd = cmd;
      w.count = cnt;
      w.day = d;
      w.month = m;
      w.year = y;
      w.drain = drain;
      pending_q.push_back(w);
   endtask

   // A word marked for draining is held back until every expected result is in.
   always @(posedge clock) begin : request_driver
      logic busy;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_wait = draw_wait(send_calm);
      end else begin
         busy = req_tvalid;
         if (req_tvalid && req_tready) begin
            date_expect_q.push_back(shift_date_back(pending_q[0]));
            pending_q.pop_front();
            busy = 1'b0;
            send_wait = draw_wait(send_calm);
         end
         if (!busy) begin
            if (send_wait > 0) begin
               send_wait--;
            end else if (pending_q.size() > 0 &&
                         !(pending_q[0].drain && date_expect_q.size() > 0)) begin
               req_tdata <= {{(cds_pkg::REQ_DATA_W - REQ_USED_W){1'b0}},
                             pending_q[0].year, pending_q[0].month, pending_q[0].day,
                             pending_q[0].count, pending_q[0].cmd};
               busy = 1'b1;
            end
         end
         req_tvalid <= busy;
      end
   end

   always @(posedge clock) begin : response_monitor
      logic         ready;
      date_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_wait = draw_wait(recv_calm);
      end else begin
         ready = rsp_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (date_expect_q.size() == 0) begin
               $error("response word arrived with no expected result pending");
               mismatches++;
            end else begin
               want = date_expect_q.pop_front();
               if (rsp_tdata[4:0] !== want.day) begin
                  $error("day_out: expected %0d, got %0d", want.day, rsp_tdata[4:0]);
                  mismatches++;
               end
               if (rsp_tdata[8:5] !== want.month) begin
                  $error("month_out: expected %0d, got %0d", want.month, rsp_tdata[8:5]);
                  mismatches++;
               end
               if (rsp_tdata[22:9] !== want.year) begin
                  $error("year_out: expected %0d, got %0d", want.year, rsp_tdata[22:9]);
                  mismatches++;
               end
               if (rsp_tuser[0] !== want.underflow) begin
                  $error("underflow: expected %0d, got %0d", want.underflow, rsp_tuser[0]);
                  mismatches++;
               end
               if (rsp_tdata[cds_pkg::RSP_DATA_W-1:RSP_USED_W] !== '0) begin
                  $error("rsp_tdata padding: expected 0, got %0h",
                         rsp_tdata[cds_pkg::RSP_DATA_W-1:RSP_USED_W]);
                  mismatches++;
               end
            end
            ready = 1'b0;
            recv_wait = draw_wait(recv_calm);
         end
         if (!ready) begin
            if (recv_wait > 0) begin
               recv_wait--;
            end else begin
               ready = 1'b1;
            end
         end
         rsp_tready <= ready;
      end
   end

   initial begin : stimulus
      logic [cds_pkg::CMD_W-1:0]       cmd;
      logic [cds_pkg::CNT_FIELD_W-1:0] cnt;
      logic [cds_pkg::DAY_W-1:0]       d;
      logic [cds_pkg::MONTH_W-1:0]     m;
      logic [cds_pkg::YEAR_W-1:0]      y;
      int unsigned                     len;

      add_item(cds_pkg::CMD_DAYS, 0, 1, 1, 1, 0);
      add_item(cds_pkg::CMD_DAYS, 1, 1, 1, 1, 0);
      add_item(cds_pkg::CMD_DAYS, 1, 1, 3, 2000, 0);
      add_item(cds_pkg::CMD_DAYS, 1, 1, 3, 1900, 0);
      add_item(cds_pkg::CMD_DAYS, 1, 1, 1, 2024, 0);
      add_item(cds_pkg::CMD_DAYS, 65535, 31, 12, 9999, 0);
      add_item(cds_pkg::CMD_WEEKS, 65535, 31, 12, 9999, 0);
      add_item(cds_pkg::CMD_WEEKS, 1, 5, 1, 1, 0);
      add_item(cds_pkg::CMD_MONTHS, 1, 31, 3, 2023, 0);
      add_item(cds_pkg::CMD_MONTHS, 2, 31, 3, 2024, 0);
      add_item(cds_pkg::CMD_MONTHS, 1, 15, 1, 1, 0);
      add_item(cds_pkg::CMD_MONTHS, 65535, 31, 12, 9999, 0);
      add_item(cds_pkg::CMD_YEARS, 1, 29, 2, 2024, 0);
      add_item(cds_pkg::CMD_YEARS, 4, 29, 2, 2024, 0);
      add_item(cds_pkg::CMD_YEARS, 65535, 31, 12, 9999, 0);
      add_item(cds_pkg::CMD_YEARS_DIRECT, 4, 29, 2, 2024, 0);
      add_item(cds_pkg::CMD_YEARS_DIRECT, 9998, 31, 12, 9999, 0);
      add_item(cds_pkg::CMD_YEARS_DIRECT, 65535, 31, 12, 9999, 0);
      add_item(CMD_UNKNOWN_LO, 100, 15, 6, 1500, 0);
      add_item(CMD_UNKNOWN_HI, 65535, 31, 2, 2023, 0);
      add_item(cds_pkg::CMD_DAYS, 0, 0, 0, 0, 0);
      add_item(cds_pkg::CMD_DAYS, 0, 31, 15, 16383, 0);
      add_item(cds_pkg::CMD_YEARS, 0, 31, 2, 2023, 0);

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if ($urandom_range(0, 9) != 0) begin
            if ($urandom_range(0, 99) < 3) begin
               cmd = cds_pkg::CMD_W'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
            end else begin
               cmd = cds_pkg::CMD_W'($urandom_range(cds_pkg::CMD_DAYS,
                                                    cds_pkg::CMD_YEARS_DIRECT));
            end
            m = cds_pkg::MONTH_W'($urandom_range(cds_pkg::MONTH_JAN, cds_pkg::MONTH_DEC));
            case ($urandom_range(0, 9))
               0, 1:    y = cds_pkg::YEAR_W'($urandom_range(1, 3));
               2:       y = cds_pkg::YEAR_W'($urandom_range(1, 99) * 100
                                             + $urandom_range(0, 1));
               default: y = cds_pkg::YEAR_W'($urandom_range(cds_pkg::YEAR_ONE,
                                                            cds_pkg::YEAR_MAX));
            endcase
            len = days_in_month(32'(m), 32'(y));
            d = cds_pkg::DAY_W'($urandom_range(0, 1) ? len - $urandom_range(0, 2)
                                                     : $urandom_range(1, len));
         end else begin
            cmd = cds_pkg::CMD_W'($urandom);
            d = cds_pkg::DAY_W'($urandom);
            m = cds_pkg::MONTH_W'($urandom);
            y = cds_pkg::YEAR_W'($urandom);
         end
         case (cmd)
            cds_pkg::CMD_DAYS, cds_pkg::CMD_WEEKS: begin
               case ($urandom_range(0, 19))
                  0:       cnt = cds_pkg::CNT_FIELD_W'($urandom);
                  1, 2, 3: cnt = cds_pkg::CNT_FIELD_W'($urandom_range(0, 5000));
                  default: cnt = cds_pkg::CNT_FIELD_W'($urandom_range(0, 400));
               endcase
            end
            cds_pkg::CMD_MONTHS, cds_pkg::CMD_YEARS: begin
               cnt = cds_pkg::CNT_FIELD_W'(($urandom_range(0, 9) == 0) ?
                                           $urandom_range(0, 600) : $urandom_range(0, 40));
            end
            cds_pkg::CMD_YEARS_DIRECT: begin
               cnt = cds_pkg::CNT_FIELD_W'($urandom_range(0, 1) ?
                                           $urandom : $urandom_range(0, 32'(y) + 1));
            end
            default: begin
               cnt = cds_pkg::CNT_FIELD_W'($urandom);
            end
         endcase
         add_item(cmd, cnt, d, m, y, (k == 0) || (k == RANDOM_ITEMS / 2));
      end

      while (pending_q.size() != 0) @(posedge clock);
      while (date_expect_q.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin : watchdog
      #100ms;
      $display("FAILURE");
      $finish;
   end

endmodule
